// ===== rtl/ragmt_pkg.sv =====
// Package: shared types and states for the range-add global-max tree.
package ragmt_pkg;

    localparam int unsigned POS_W = 10;
    localparam int unsigned DELTA_W = 16;
    localparam int unsigned CNT_W = 32;

    typedef struct packed {
        logic [POS_W-1:0]          range_low;
        logic [POS_W-1:0]          range_high;
        logic signed [DELTA_W-1:0] delta;
    } req_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] global_max;
        logic                    range_error;
    } rsp_t;

    // One tree node word: maximum and pending tag
    typedef struct packed {
        logic [CNT_W-1:0] nmax;
        logic [CNT_W-1:0] lazy;
    } node_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE,
        S_NODE_D,
        S_PA,
        S_PB,
        S_DESC,
        S_RET,
        S_RC0,
        S_RC1,
        S_RC2,
        S_FIN,
        S_OUT
    } state_t;

endpackage

// ===== rtl/ragmt_ram.sv =====
// Simple dual-port node memory: one write, one registered read per cycle.
module ragmt_ram #(
    parameter int unsigned AW = 11,
    parameter int unsigned DW = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/range_add_global_max_tree_core.sv =====
// Range-add / global-max lazy segment tree over LEAVES positions. After reset a
// clearing pass zeroes the node memory; req_ready stays low meanwhile. Each
// request then walks the tree with an explicit frame stack and a single-port-read
// node memory: a fully covered node is read and written back with the delta added,
// a partially covered node on the way down is read and first pushes any pending tag
// to both children, a partial node on the way back up has its maximum rebuilt from
// its children, and a split turns to its right half once the left is done. At the
// end the root is read out as the response. An invalid range (low above high, or
// high at or past LEAVES) skips the walk and returns the current maximum with
// range_error set. One request at a time.
module range_add_global_max_tree_core #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ragmt_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ragmt_pkg::rsp_t rsp
);
    import ragmt_pkg::*;

    localparam int unsigned PW  = $clog2(LEAVES);
    localparam int unsigned AW  = PW + 1;
    localparam int unsigned SD  = PW + 1;
    localparam int unsigned SIW = $clog2(SD);
    localparam int unsigned SPW = $clog2(SD + 1);
    localparam int unsigned CW  = AW + 1;

    typedef struct packed {
        logic [PW-1:0] l;
        logic [PW-1:0] r;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        logic          pend;
    } frame_t;

    state_t state_reg, state_next;
    logic [PW-1:0] l_reg, l_next, r_reg, r_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0] d_reg, d_next, lz_reg, lz_next, amax_reg, amax_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic err_reg, err_next;
    logic [SPW-1:0] sp_reg;
    frame_t stk [SD];
    logic rsp_valid_reg;

    // Stack controls
    logic push, pop, clr_pend;
    frame_t push_frame, top;
    logic [SPW-1:0] top_ptr;

    // Memory port
    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    node_t mem_wdata, rd;
    logic rsp_load;

    // Node geometry of the current frame
    logic [PW:0] lr_sum, mr_sum;
    logic [PW-1:0] mid, mid1, tmid, tmid1;
    logic [AW-1:0] cur_id, a_id, b_id, root_id;
    logic full;

    assign top_ptr = sp_reg - SPW'(1);
    assign top     = stk[top_ptr[SIW-1:0]];

    assign lr_sum  = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid     = lr_sum[PW:1];
    assign mid1    = mid + PW'(1);
    assign cur_id  = lr_sum | AW'(l_reg != r_reg);
    assign a_id    = ({1'b0, l_reg} + {1'b0, mid}) | AW'(l_reg != mid);
    assign b_id    = ({1'b0, mid1} + {1'b0, r_reg}) | AW'(mid1 != r_reg);
    assign root_id = AW'(LEAVES - 1) | AW'(1);
    assign full    = (lo_reg == l_reg) && (hi_reg == r_reg);

    assign mr_sum  = {1'b0, top.l} + {1'b0, top.r};
    assign tmid    = mr_sum[PW:1];
    assign tmid1   = tmid + PW'(1);

    ragmt_ram #(.AW(AW), .DW(2 * CNT_W)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (push)
            begin
                sp_reg <= sp_reg + SPW'(1);
            end
            else if (pop)
            begin
                sp_reg <= top_ptr;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers and frame stack
    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        d_reg    <= d_next;
        lz_reg   <= lz_next;
        amax_reg <= amax_next;
        err_reg  <= err_next;
        if (push)
        begin
            stk[sp_reg[SIW-1:0]] <= push_frame;
        end
        if (clr_pend)
        begin
            stk[top_ptr[SIW-1:0]].pend <= 1'b0;
        end
        if (rsp_load)
        begin
            rsp.global_max  <= rd.nmax;
            rsp.range_error <= err_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign req_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        d_next     = d_reg;
        lz_next    = lz_reg;
        amax_next  = amax_reg;
        err_next   = err_reg;
        clr_next   = clr_reg;
        push       = 1'b0;
        pop        = 1'b0;
        clr_pend   = 1'b0;
        push_frame = '{l: l_reg, r: r_reg, lo: lo_reg, hi: hi_reg, pend: 1'b0};
        mem_we     = 1'b0;
        mem_waddr  = cur_id;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = cur_id;
        rsp_load   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(2 * LEAVES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    l_next   = '0;
                    r_next   = PW'(LEAVES - 1);
                    lo_next  = PW'(req.range_low);
                    hi_next  = PW'(req.range_high);
                    d_next   = CNT_W'(req.delta);
                    err_next = (req.range_low > req.range_high)
                            || (32'(req.range_high) >= 32'(LEAVES));
                    state_next = err_next ? S_FIN : S_NODE;
                end
            end
            S_NODE:
            begin
                mem_re     = 1'b1;
                state_next = S_NODE_D;
            end
            S_NODE_D:
            begin
                if (full)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{nmax: rd.nmax + d_reg, lazy: rd.lazy + d_reg};
                    state_next = S_RET;
                end
                else
                begin
                    lz_next = rd.lazy;
                    if (rd.lazy != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = a_id;
                        state_next = S_PA;
                    end
                    else
                    begin
                        state_next = S_DESC;
                    end
                end
            end
            // Pushdown of the pending tag to both children
            S_PA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = a_id;
                mem_wdata  = '{nmax: rd.nmax + lz_reg, lazy: rd.lazy + lz_reg};
                mem_re     = 1'b1;
                mem_raddr  = b_id;
                state_next = S_PB;
            end
            S_PB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = b_id;
                mem_wdata  = '{nmax: rd.nmax + lz_reg, lazy: rd.lazy + lz_reg};
                state_next = S_DESC;
            end
            S_DESC:
            begin
                push       = 1'b1;
                state_next = S_NODE;
                if (hi_reg <= mid)
                begin
                    r_next = mid;
                end
                else if (lo_reg > mid)
                begin
                    l_next = mid1;
                end
                else
                begin
                    push_frame.pend = 1'b1;
                    r_next  = mid;
                    hi_next = mid;
                end
            end
            S_RET:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (top.pend)
                begin
                    // Left half done, start the right half
                    clr_pend   = 1'b1;
                    l_next     = tmid1;
                    r_next     = top.r;
                    lo_next    = tmid1;
                    hi_next    = top.hi;
                    state_next = S_NODE;
                end
                else
                begin
                    pop        = 1'b1;
                    l_next     = top.l;
                    r_next     = top.r;
                    lo_next    = top.lo;
                    hi_next    = top.hi;
                    state_next = S_RC0;
                end
            end
            // Recompute parent maximum from its children
            S_RC0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = a_id;
                state_next = S_RC1;
            end
            S_RC1:
            begin
                amax_next  = rd.nmax;
                mem_re     = 1'b1;
                mem_raddr  = b_id;
                state_next = S_RC2;
            end
            S_RC2:
            begin
                mem_we = 1'b1;
                mem_wdata.lazy = '0;
                mem_wdata.nmax = ($signed(amax_reg) > $signed(rd.nmax)) ? amax_reg : rd.nmax;
                state_next = S_RET;
            end
            S_FIN:
            begin
                mem_re     = 1'b1;
                mem_raddr  = root_id;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/range_max_checker.sv =====
// Checker: watches both channels, predicts the global maximum and compares.
`timescale 1ns / 1ps

module range_max_checker #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  ragmt_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  ragmt_pkg::rsp_t rsp,
    output int              fail_count,
    output int              pending_count
);
    import ragmt_pkg::*;

    // Shadow tree, same node layout as the block
    logic [31:0] tree_max[2*LEAVES];
    logic [31:0] tree_tag[2*LEAVES];
    rsp_t        expected_q[$];

    assign pending_count = expected_q.size();

    function automatic int unsigned node_index(int unsigned l, int unsigned r);
        return (l + r) | ((l != r) ? 1 : 0);
    endfunction

    function automatic void add_tag(int unsigned id, logic [31:0] d);
        tree_max[id] = tree_max[id] + d;
        tree_tag[id] = tree_tag[id] + d;
    endfunction

    // Recursive lazy range add with pushdown and max rebuild
    function automatic void add_span(int unsigned l, int unsigned r, int unsigned lo,
                                     int unsigned hi, logic [31:0] d);
        int unsigned id;
        int unsigned mid;
        int unsigned a;
        int unsigned b;
        id = node_index(l, r);
        if (lo == l && hi == r) begin
            add_tag(id, d);
            return;
        end
        mid = (l + r) >> 1;
        a = node_index(l, mid);
        b = node_index(mid + 1, r);
        if (tree_tag[id] != 0) begin
            add_tag(a, tree_tag[id]);
            add_tag(b, tree_tag[id]);
            tree_tag[id] = 0;
        end
        if (hi <= mid)
            add_span(l, mid, lo, hi, d);
        else if (lo > mid)
            add_span(mid + 1, r, lo, hi, d);
        else
        begin
            add_span(l, mid, lo, mid, d);
            add_span(mid + 1, r, mid + 1, hi, d);
        end
        tree_max[id] = ($signed(tree_max[a]) > $signed(tree_max[b])) ? tree_max[a]
                                                                     : tree_max[b];
    endfunction

    function automatic rsp_t predict_update(req_t r);
        rsp_t res;
        logic [31:0] d;
        d = {{16{r.delta[15]}}, r.delta};
        res.range_error = (r.range_low > r.range_high) || (r.range_high >= LEAVES);
        if (!res.range_error)
            add_span(0, LEAVES - 1, r.range_low, r.range_high, d);
        res.global_max = tree_max[node_index(0, LEAVES - 1)];
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < 2 * LEAVES; i++)
        begin
            tree_max[i] = 0;
            tree_tag[i] = 0;
        end
        fail_count = 0;
    end

    // Predict on request transfer, compare on response transfer
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && req_valid && req_ready)
            expected_q.push_back(predict_update(req));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("response transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.global_max !== want.global_max)
                begin
                    $error("global_max expected %0d got %0d", want.global_max,
                           rsp.global_max);
                    fail_count++;
                end
                if (rsp.range_error !== want.range_error)
                begin
                    $error("range_error expected %0b got %0b", want.range_error,
                           rsp.range_error);
                    fail_count++;
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Testbench top: stimulus, idling, verdict for the range-add global-max tree.
`timescale 1ns / 1ps

module testbench;
    import ragmt_pkg::*;

    localparam int unsigned LEAVES = 1024;
    localparam int RANDOM_ITEMS = 480;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   fail_count;
    int   pending_count;
    int   sent_count;
    int   error_count;
    bit   hold_rsp;

    range_add_global_max_tree_core #(.LEAVES(LEAVES)) DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    range_max_checker #(.LEAVES(LEAVES)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // One request transfer, then an optional gap
    task automatic send_update(logic [9:0] lo, logic [9:0] hi, logic [15:0] d);
        int g;
        req_valid <= 1'b1;
        req <= '{range_low: lo, range_high: hi, delta: d};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_count++;
        if (lo > hi || hi >= LEAVES) error_count++;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [9:0] lo;
        logic [9:0] hi;
        logic [15:0] d;
        int p;
        p = $urandom_range(0, 99);
        lo = 10'($urandom_range(0, 1023));
        hi = 10'($urandom_range(lo, 1023));
        if (p < 35)
        begin
            // narrow range
            hi = lo + 10'($urandom_range(0, 7));
            if (hi < lo) hi = 10'h3ff;
        end
        else if (p < 45)
        begin
            // independent ends, often inverted
            lo = 10'($urandom_range(0, 1023));
            hi = 10'($urandom_range(0, 1023));
        end
        else if (p < 50)
            lo = 0;
        d = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            d = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
        send_update(lo, hi, d);
    endtask

    // Receiver: random stalls, with one forced long hold
    initial
    begin
        int g;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rsp = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        sent_count = 0;
        error_count = 0;
        hold_rsp = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, overflow, invalid ranges, zero delta
        send_update(10'd0, 10'd1023, 16'sh7fff);
        send_update(10'd0, 10'd0, 16'sh8000);
        send_update(10'd1023, 10'd1023, 16'sh7fff);
        send_update(10'd5, 10'd4, 16'sh0100);
        send_update(10'd1023, 10'd0, 16'sh0001);
        send_update(10'd512, 10'd511, 16'sh0001);
        send_update(10'd3, 10'd700, 16'sh0000);
        send_update(10'd511, 10'd512, 16'shffff);
        send_update(10'd0, 10'd511, 16'sh8000);
        send_update(10'd512, 10'd1023, 16'sh8000);
        for (int i = 0; i < 8; i++)
            send_update(10'd1, 10'd1022, 16'sh7fff);
        send_update(10'h2aa, 10'h3d5, 16'sh5555);
        send_update(10'h155, 10'h2aa, 16'shaaaa);
        // A ramp of maximum adds to one leaf drives its count past the 16-bit delta range
        for (int i = 0; i < 4; i++)
            send_update(10'd100, 10'd100, 16'sh7fff);

        // Sender pauses until everything has drained
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2) hold_rsp = 1;
            send_random();
        end
        req_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d updates, %0d with an invalid range, with stalls on both sides.",
                 sent_count, error_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
